// ===== design/rpf_pkg.sv =====
// rpf_pkg: shared types and constants of the rgb pixel filter stream
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rpf_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;

  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    REG_FILTER_MODE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_SEPIA  = 2'd0,
    MODE_GRAY   = 2'd1,
    MODE_BLUR   = 2'd2,
    MODE_INVERT = 2'd3
  } mode_e;

  // how the result of one item is formed
  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_MEAN  = 2'd1,
    KIND_PASS  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic  res;
    logic  pix_item;
    kind_e kind;
    mode_e mode;
    logic  frame_end;
  } ctrl_t;

  // sepia weights, 16 fraction bits; row = output channel, column = r g b
  localparam logic [15:0] SEPIA_W [3][3] = '{
    '{16'd25756, 16'd50397, 16'd12386},
    '{16'd22872, 16'd44958, 16'd11010},
    '{16'd17826, 16'd34996, 16'd8585}
  };

  // floor(x / 5) == (x * DIV5_MUL) >> DIV5_SHIFT for the blur sums
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int unsigned DIV5_SHIFT = 18;

endpackage

// ===== design/rpf_if.sv =====
// rpf channel interfaces: pixel input, filtered output and register write
// depends on rpf_pkg for the register write types
`timescale 1ns / 1ps

interface rpf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, command, red_in, green_in, blue_in, input ready);
  modport sink (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

interface rpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;
  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface rpf_cfg_if;
  logic                valid;
  logic                ready;
  rpf_pkg::cfg_idx_t   index;
  rpf_pkg::cfg_data_t  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/rpf_line_store.sv =====
// rpf_line_store: middle and upper line memories with registered reads
// depends on rpf_pkg
`timescale 1ns / 1ps

module rpf_line_store #(
  parameter int unsigned MAX_WIDTH = rpf_pkg::MAX_WIDTH_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] rd_addr_a_i,
  input  logic [AW-1:0] rd_addr_b_i,
  input  logic          wr_mid_i,
  input  logic [AW-1:0] wr_mid_addr_i,
  input  rpf_pkg::rgb_t wr_mid_data_i,
  input  logic          wr_up_i,
  input  logic [AW-1:0] wr_up_addr_i,
  output rpf_pkg::rgb_t center_o,
  output rpf_pkg::rgb_t right_o,
  output rpf_pkg::rgb_t up_o
);
  import rpf_pkg::*;

  rgb_t mid_mem [MAX_WIDTH];
  rgb_t up_mem [MAX_WIDTH];
  rgb_t center_q, right_q, up_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      center_q <= mid_mem[rd_addr_a_i];
      right_q  <= mid_mem[rd_addr_b_i];
      up_q     <= up_mem[rd_addr_a_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_mid_i) begin
      mid_mem[wr_mid_addr_i] <= wr_mid_data_i;
    end
  end

  // the row above moves up once its read has come back
  always_ff @(posedge clk_i) begin
    if (wr_up_i) begin
      up_mem[wr_up_addr_i] <= center_q;
    end
  end

  assign center_o = center_q;
  assign right_o  = right_q;
  assign up_o     = up_q;

endmodule

// ===== design/rpf_pixel_math.sv =====
// rpf_pixel_math: point filters and 5-point mean, two stages plus output register
// depends on rpf_pkg
`timescale 1ns / 1ps

module rpf_pixel_math (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  rpf_pkg::ctrl_t s1_ctrl_i,
  input  rpf_pkg::rgb_t  s1_pix_i,
  input  rpf_pkg::rgb_t  center_i,
  input  rpf_pkg::rgb_t  right_i,
  input  rpf_pkg::rgb_t  up_i,
  output logic           res_valid_o,
  output rpf_pkg::rgb_t  res_o,
  output logic           res_end_o
);
  import rpf_pkg::*;

  rgb_t        left_q;
  logic [7:0]  pix_ch [3];
  logic [7:0]  lf_ch [3];
  logic [7:0]  ct_ch [3];
  logic [7:0]  rt_ch [3];
  logic [7:0]  up_ch [3];
  logic [23:0] prod_d [3][3];
  logic [10:0] bsum_d [3];
  logic [12:0] gray_sum;

  ctrl_t       s2_ctrl_q;
  logic [23:0] prod_q [3][3];
  logic [10:0] bsum_q [3];
  logic [7:0]  gray_q;
  rgb_t        inv_q, pass_q;

  logic [25:0] sep_sum [3];
  logic [26:0] div_prod [3];
  logic [7:0]  res_ch [3];
  rgb_t        res_d;

  logic        out_v_q;
  rgb_t        out_q;
  logic        out_end_q;

  always_comb begin
    pix_ch = '{s1_pix_i.r, s1_pix_i.g, s1_pix_i.b};
    lf_ch  = '{left_q.r, left_q.g, left_q.b};
    ct_ch  = '{center_i.r, center_i.g, center_i.b};
    rt_ch  = '{right_i.r, right_i.g, right_i.b};
    up_ch  = '{up_i.r, up_i.g, up_i.b};
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[c][k] = SEPIA_W[c][k] * pix_ch[k];
      end
      bsum_d[c] = 11'(lf_ch[c]) + 11'(ct_ch[c]) + 11'(rt_ch[c]) + 11'(up_ch[c])
                + 11'(pix_ch[c]);
    end
    gray_sum = 13'(11 * s1_pix_i.r) + 13'({s1_pix_i.g, 4'b0}) + 13'(5 * s1_pix_i.b);
  end

  // left neighbour is the center read of the previous pixel transfer
  always_ff @(posedge clk_i) begin
    if (en_i && s1_ctrl_i.pix_item) begin
      left_q <= center_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctrl_q <= '0;
    end else if (en_i) begin
      s2_ctrl_q <= s1_ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      bsum_q <= bsum_d;
      gray_q <= gray_sum[12:5];
      inv_q  <= ~s1_pix_i;
      pass_q <= center_i;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sep_sum[c]  = 26'(prod_q[c][0]) + 26'(prod_q[c][1]) + 26'(prod_q[c][2]);
      div_prod[c] = bsum_q[c] * DIV5_MUL;
      res_ch[c]   = 8'd0;
      case (s2_ctrl_q.kind)
        KIND_MEAN: res_ch[c] = div_prod[c][DIV5_SHIFT+7:DIV5_SHIFT];
        KIND_PASS: res_ch[c] = pass_q[23-8*c -: 8];
        default: begin
          case (s2_ctrl_q.mode)
            MODE_SEPIA: res_ch[c] = (sep_sum[c][25:24] != 2'b0) ? 8'hff : sep_sum[c][23:16];
            MODE_GRAY:  res_ch[c] = gray_q;
            default:    res_ch[c] = inv_q[23-8*c -: 8];
          endcase
        end
      endcase
    end
    res_d = '{r: res_ch[0], g: res_ch[1], b: res_ch[2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= s2_ctrl_q.res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q     <= res_d;
      out_end_q <= s2_ctrl_q.frame_end;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;
  assign res_end_o   = out_end_q;

endmodule

// ===== design/rgb_pixel_filter_stream.sv =====
// rgb_pixel_filter_stream: top level, registers, raster counters and pipeline control
// depends on rpf_pkg, rpf_if, rpf_line_store and rpf_pixel_math
`timescale 1ns / 1ps

// Usage
//   in_ch  : raster-order pixels (command 0) or drain items (command 1)
//   out_ch : filtered pixels in raster order, frame_end on the last one
//   cfg_ch : register writes (filter mode, width, height), always ready;
//            writing width or height restarts the frame
// Sepia, grayscale and invert give one result per pixel. Blur gives the
// result of the row above, so a frame's last row comes out on drain items
// sent after its last pixel.
// Results pass through the s1, s2 and output registers before out_ch.valid.
// Throughput: one item per cycle while out_ch does not stall; the middle line
// memory is written at accept and the upper one as the item leaves s1, so each memory port serves one item a cycle.
// Reset clears counters, pipeline valids and registers (mode sepia, 640x480);
// line memories are not cleared and need no pass.
// A stalled output register freezes the whole pipeline and drops in_ch.ready
// in the same cycle; nothing is lost.
module rgb_pixel_filter_stream #(
  parameter int unsigned MAX_WIDTH = rpf_pkg::MAX_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rpf_in_if.sink    in_ch,
  rpf_out_if.source out_ch,
  rpf_cfg_if.sink   cfg_ch
);
  import rpf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  mode_e         mode_q;
  logic [11:0]   width_q;
  logic [15:0]   height_q;
  logic [AW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;
  logic [AW-1:0] dpos_q, dpos_d;
  logic          pend_q, pend_d;

  logic          en, accept, res_valid, res_end;
  rgb_t          res;
  logic [31:0]   w_ext;
  logic [WW-1:0] w_eff, w_m1;
  logic [15:0]   h_eff;
  logic [AW-1:0] x, xr, d, rd_a;
  logic [15:0]   y;
  logic          x_last, y_last, d_last, tiny, border;
  rgb_t          pix;
  ctrl_t         ctrl_d, s1_ctrl_q;
  rgb_t          s1_pix_q;
  logic [AW-1:0] s1_addr_q;
  rgb_t          center, right, up;

  assign en          = !res_valid || out_ch.ready;
  assign in_ch.ready = en;
  assign accept      = in_ch.valid && en;
  assign cfg_ch.ready = 1'b1;
  assign pix = '{r: in_ch.red_in, g: in_ch.green_in, b: in_ch.blue_in};

  always_comb begin
    w_ext = 32'(width_q);
    if (w_ext == 32'd0) begin
      w_ext = 32'd1;
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      w_ext = 32'(MAX_WIDTH);
    end
    w_eff  = WW'(w_ext);
    w_m1   = w_eff - WW'(1);
    h_eff  = (height_q == 16'd0) ? 16'd1 : height_q;
    x      = (WW'(col_q) < w_eff) ? col_q : '0;
    y      = (row_q < h_eff) ? row_q : 16'd0;
    x_last = (WW'(x) == w_m1);
    y_last = (y == h_eff - 16'd1);
    xr     = ((WW'(x) + WW'(1)) < w_eff) ? x + AW'(1) : x;
    d      = (WW'(dpos_q) < w_eff) ? dpos_q : AW'(w_m1);
    d_last = (WW'(d) == w_m1);
    tiny   = (w_eff < WW'(3)) || (h_eff < 16'd3);
    border = tiny || (x == '0) || x_last || (y == 16'd1);
    rd_a   = in_ch.command ? d : x;
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    dpos_d = dpos_q;
    pend_d = pend_q;
    ctrl_d = '{res: 1'b0, pix_item: 1'b0, kind: KIND_POINT, mode: mode_q, frame_end: 1'b0};
    if (accept) begin
      if (in_ch.command) begin
        if (pend_q) begin
          ctrl_d.res       = 1'b1;
          ctrl_d.kind      = KIND_PASS;
          ctrl_d.frame_end = d_last;
          if (d_last) begin
            pend_d = 1'b0;
            dpos_d = '0;
          end else begin
            dpos_d = d + AW'(1);
          end
        end
      end else begin
        ctrl_d.pix_item = 1'b1;
        dpos_d = '0;
        pend_d = (mode_q == MODE_BLUR) && x_last && y_last;
        if (x_last) begin
          col_d = '0;
          row_d = y_last ? 16'd0 : y + 16'd1;
        end else begin
          col_d = x + AW'(1);
          row_d = y;
        end
        if (mode_q != MODE_BLUR) begin
          ctrl_d.res       = 1'b1;
          ctrl_d.frame_end = x_last && y_last;
        end else begin
          ctrl_d.res  = (y != 16'd0);
          ctrl_d.kind = border ? KIND_PASS : KIND_MEAN;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SEPIA;
      width_q  <= 12'd640;
      height_q <= 16'd480;
      col_q    <= '0;
      row_q    <= 16'd0;
      dpos_q   <= '0;
      pend_q   <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      dpos_q <= dpos_d;
      pend_q <= pend_d;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_FILTER_MODE: mode_q <= mode_e'(cfg_ch.data[1:0]);
          REG_IMAGE_WIDTH: begin
            width_q <= cfg_ch.data[11:0];
            col_q   <= '0;
            row_q   <= 16'd0;
            dpos_q  <= '0;
            pend_q  <= 1'b0;
          end
          REG_IMAGE_HEIGHT: begin
            height_q <= cfg_ch.data;
            col_q    <= '0;
            row_q    <= 16'd0;
            dpos_q   <= '0;
            pend_q   <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctrl_q <= '0;
    end else if (en) begin
      s1_ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pix_q  <= pix;
      s1_addr_q <= x;
    end
  end

  rpf_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i         (clk_i),
    .en_i          (en),
    .rd_addr_a_i   (rd_a),
    .rd_addr_b_i   (xr),
    .wr_mid_i      (accept && !in_ch.command),
    .wr_mid_addr_i (x),
    .wr_mid_data_i (pix),
    .wr_up_i       (en && s1_ctrl_q.pix_item),
    .wr_up_addr_i  (s1_addr_q),
    .center_o      (center),
    .right_o       (right),
    .up_o          (up)
  );

  rpf_pixel_math u_pixel_math (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .s1_ctrl_i   (s1_ctrl_q),
    .s1_pix_i    (s1_pix_q),
    .center_i    (center),
    .right_i     (right),
    .up_i        (up),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_end_o   (res_end)
  );

  assign out_ch.valid     = res_valid;
  assign out_ch.red_out   = res.r;
  assign out_ch.green_out = res.g;
  assign out_ch.blue_out  = res.b;
  assign out_ch.frame_end = res_end;

endmodule
